### hw/rtl/led_ps_pkg.sv
// Shared types and constants for the LED pattern sequencer.
package led_ps_pkg;

  localparam int PROGRAM_BYTES_DEF = 4096;
  localparam int LED_COUNT_DEF     = 32;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int LED_BITS_W = 32;
  localparam int CAUSE_W    = 2;
  localparam int WAIT_W     = 64;
  localparam int OPERAND_W  = 6;
  localparam int LED_MAX    = 64;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_HALT  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_SET_LED  = 2'd0,
    OP_WAIT     = 2'd1,
    OP_REWIND   = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_RESERVED  = 2'd1,
    CAUSE_PAST_END  = 2'd2,
    CAUSE_ZERO_WAIT = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OP,
    ST_RD_ARG,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/led_ps_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface led_ps_in_if;
  import led_ps_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output kind, output byte_address, output byte_value,
                  input ready);
  modport sink (input valid, input kind, input byte_address, input byte_value,
                output ready);
endinterface

interface led_ps_out_if;
  import led_ps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LED_BITS_W-1:0] led_bits;
  logic                  running;
  logic [CAUSE_W-1:0]    stop_cause;

  modport source (output valid, output led_bits, output running, output stop_cause,
                  input ready);
  modport sink (input valid, input led_bits, input running, input stop_cause,
                output ready);
endinterface

### hw/rtl/led_pattern_sequencer_unit.sv
// Top level of the LED pattern sequencer: control sequencer, program store and datapath.
// Writes, starts, halts and ticks that only count down go from the idle state through the done state to a result.
// A tick that runs the program passes each instruction through two reads of the single program store
// read port and one execute step, then goes through the done state to a result.
// One transaction is in flight at a time; a new one is taken once the result has left.
// After reset the program store is filled with 0xFF, one byte a cycle, over all PROGRAM_BYTES addresses.
module led_pattern_sequencer_unit #(
  parameter int PROGRAM_BYTES = led_ps_pkg::PROGRAM_BYTES_DEF,
  parameter int LED_COUNT     = led_ps_pkg::LED_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  led_ps_in_if.sink     in_chan,
  led_ps_out_if.source  out_chan
);
  import led_ps_pkg::*;

  localparam int AW  = $clog2(PROGRAM_BYTES);
  localparam int PCW = AW + 1;
  localparam logic [AW-1:0]  CLR_LAST = AW'(PROGRAM_BYTES - 1);
  localparam logic [PCW-1:0] PC_END   = PCW'(PROGRAM_BYTES);

  state_t state_r, state_nxt;

  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]        pc_r, pc_nxt;
  logic [WAIT_W-1:0]    wait_r, wait_nxt;
  logic                 active_r, active_nxt;
  logic [LED_COUNT-1:0] led_r, led_nxt;
  cause_t               cause_r, cause_nxt;
  logic [BYTE_W-1:0]    op_r;

  logic                  out_valid_r;
  logic [LED_BITS_W-1:0] out_led_r;
  logic                  out_running_r;
  cause_t                out_cause_r;

  logic in_ready;
  logic in_fire;
  logic load_out;
  logic clr_we;
  kind_t kind;
  logic wait_gt1;
  logic run_program;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              wr_in_range;

  logic [PCW-1:0]       pc_p1;
  logic [PCW-1:0]       pc_p2;
  logic [BYTE_W-1:0]    arg;
  opcode_t              opcode;
  logic [OPERAND_W-1:0] operand;
  logic [WAIT_W-1:0]    shifted;
  logic                 exec_done;
  logic [PCW-1:0]       exec_pc;
  logic [WAIT_W-1:0]    exec_wait;
  cause_t               exec_cause;
  logic [LED_COUNT-1:0] exec_led;
  logic [LED_MAX-1:0]   led_wide;

  assign kind        = kind_t'(in_chan.kind);
  assign in_fire     = in_chan.valid && in_ready;
  assign wait_gt1    = |wait_r[WAIT_W-1:1];
  assign run_program = (kind == KIND_TICK) && active_r && !wait_gt1;
  assign wr_in_range = 32'(in_chan.byte_address) < 32'(PROGRAM_BYTES);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = run_program ? ST_RD_OP : ST_DONE;
        end
      end
      ST_RD_OP:  state_nxt = ST_RD_ARG;
      ST_RD_ARG: state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = exec_done ? ST_DONE : ST_RD_OP;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    clr_we   = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we   = 1'b1;
      ST_IDLE:  in_ready = !out_valid_r;
      ST_DONE:  load_out = 1'b1;
      default: begin
      end
    endcase
  end

  assign ram_we    = clr_we || (in_fire && (kind == KIND_WRITE) && wr_in_range);
  assign ram_waddr = clr_we ? clr_cnt_r : AW'(in_chan.byte_address);
  assign ram_wdata = clr_we ? ERASED_BYTE : in_chan.byte_value;
  assign pc_p1     = PCW'(pc_r) + PCW'(1);
  assign pc_p2     = PCW'(pc_r) + PCW'(2);
  assign ram_raddr = (state_r == ST_RD_ARG) ? pc_p1[AW-1:0] : pc_r;

  led_ps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PROGRAM_BYTES)
  ) u_program_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign opcode  = opcode_t'(op_r[BYTE_W-1:BYTE_W-2]);
  assign operand = op_r[OPERAND_W-1:0];
  assign arg     = (pc_p1 >= PC_END) ? ERASED_BYTE : ram_rdata;

  led_ps_shift u_shift (
    .value  (arg),
    .amount (operand),
    .result (shifted)
  );

  // One instruction step.
  always_comb begin
    exec_led   = led_r;
    exec_pc    = pc_p2;
    exec_wait  = '0;
    exec_cause = CAUSE_NONE;
    exec_done  = 1'b0;
    unique case (opcode)
      OP_SET_LED: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          if (operand == OPERAND_W'(i)) begin
            exec_led[i] = arg[BYTE_W-1];
          end
        end
      end
      OP_WAIT: begin
        exec_wait  = shifted;
        exec_cause = (shifted == '0) ? CAUSE_ZERO_WAIT : CAUSE_NONE;
        exec_done  = 1'b1;
      end
      OP_REWIND: begin
        exec_pc    = '0;
        exec_wait  = shifted;
        exec_cause = (shifted == '0) ? CAUSE_ZERO_WAIT : CAUSE_NONE;
        exec_done  = 1'b1;
      end
      OP_RESERVED: begin
        exec_pc    = '0;
        exec_cause = CAUSE_RESERVED;
        exec_done  = 1'b1;
      end
      default: begin
      end
    endcase
    if (exec_pc >= PC_END) begin
      exec_pc    = '0;
      exec_wait  = '0;
      exec_cause = CAUSE_PAST_END;
      exec_done  = 1'b1;
    end
  end

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    wait_nxt    = wait_r;
    active_nxt  = active_r;
    led_nxt     = led_r;
    cause_nxt   = cause_r;
    if (clr_we) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (in_fire) begin
      cause_nxt = CAUSE_NONE;
      case (kind)
        KIND_START: begin
          pc_nxt     = '0;
          wait_nxt   = WAIT_W'(1);
          active_nxt = 1'b1;
        end
        KIND_HALT: begin
          active_nxt = 1'b0;
          wait_nxt   = '0;
        end
        KIND_TICK: begin
          if (active_r) begin
            wait_nxt = wait_gt1 ? (wait_r - WAIT_W'(1)) : '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == ST_EXEC) begin
      led_nxt = exec_led;
      pc_nxt  = exec_pc[AW-1:0];
      if (exec_done) begin
        cause_nxt  = exec_cause;
        wait_nxt   = exec_wait;
        active_nxt = (exec_wait != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      wait_r      <= '0;
      active_r    <= 1'b0;
      led_r       <= '0;
      cause_r     <= CAUSE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      wait_r    <= wait_nxt;
      active_r  <= active_nxt;
      led_r     <= led_nxt;
      cause_r   <= cause_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign led_wide = LED_MAX'(led_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_RD_ARG) begin
      op_r <= ram_rdata;
    end
    if (load_out) begin
      out_led_r     <= led_wide[LED_BITS_W-1:0];
      out_running_r <= active_r;
      out_cause_r   <= cause_r;
    end
  end

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.led_bits   = out_led_r;
  assign out_chan.running    = out_running_r;
  assign out_chan.stop_cause = out_cause_r;

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result transaction raised outside the completion step");

  a_stop_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cause_r != CAUSE_NONE)) |-> !out_running_r)
    else $error("stopped sequencer reported as running");

  a_active_has_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && active_r) |-> (wait_r != '0))
    else $error("running sequencer has no pending wait");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pc_r) < 32'(PROGRAM_BYTES))
    else $error("program counter outside the program store");

endmodule

### hw/rtl/led_ps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module led_ps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/led_ps_shift.sv
// Saturating shifter that scales a wait byte by two to the power of the operand.
module led_ps_shift (
  input  logic [led_ps_pkg::BYTE_W-1:0]    value,
  input  logic [led_ps_pkg::OPERAND_W-1:0] amount,
  output logic [led_ps_pkg::WAIT_W-1:0]    result
);
  import led_ps_pkg::*;

  logic [WAIT_W+BYTE_W-1:0] wide;

  always_comb begin
    wide = (WAIT_W + BYTE_W)'(value) << amount;
    if (|wide[WAIT_W+BYTE_W-1:WAIT_W]) begin
      result = '1;
    end else begin
      result = wide[WAIT_W-1:0];
    end
  end

endmodule

### dv/tb_led_pattern_sequencer_unit.sv
// Self-checking testbench for the LED pattern sequencer unit with a built-in behavioral predictor.
`timescale 1ns / 1ps

module tb_led_pattern_sequencer_unit;
  import led_ps_pkg::*;

  localparam int PROG_BYTES  = PROGRAM_BYTES_DEF;
  localparam int LEDS        = LED_COUNT_DEF;
  localparam int ITEM_TARGET = 140;
  localparam int STALL_LIMIT = 30000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [LED_BITS_W-1:0] leds;
    logic                  running;
    cause_t                cause;
  } led_result_t;

  logic clk = 1'b0;
  logic rst_n;

  led_ps_in_if  in_chan ();
  led_ps_out_if out_chan ();

  led_pattern_sequencer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  logic [BYTE_W-1:0]     prog_mem [PROG_BYTES];
  int unsigned           pc;
  logic [WAIT_W-1:0]     wait_left;
  bit                    seq_active;
  logic [LED_BITS_W-1:0] led_word;

  led_result_t expected_results [$];
  led_result_t due;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int          stall_left;
  bit          idle_on;

  function automatic void clear_model();
    foreach (prog_mem[i]) prog_mem[i] = ERASED_BYTE;
    pc         = 0;
    wait_left  = '0;
    seq_active = 1'b0;
    led_word   = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] fetch_byte(int unsigned addr);
    if (addr < PROG_BYTES) return prog_mem[addr];
    return ERASED_BYTE;
  endfunction

  function automatic logic [WAIT_W-1:0] wait_from_operand(logic [BYTE_W-1:0] arg,
                                                           int unsigned n);
    logic [WAIT_W-1:0] wide;
    wide = {{(WAIT_W-BYTE_W){1'b0}}, arg};
    if (n == 0) return wide;
    if ((wide >> (WAIT_W - n)) != 0) return '1;
    return wide << n;
  endfunction

  // Executes instructions until a new wait begins or the sequencer stops.
  function automatic cause_t run_program();
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    int unsigned       n;
    logic [WAIT_W-1:0] pend;
    cause_t            why;
    bit                done;
    pend = '0;
    why  = CAUSE_NONE;
    done = 1'b0;
    while (!done) begin
      b1 = fetch_byte(pc);
      b2 = fetch_byte(pc + 1);
      n  = b1[OPERAND_W-1:0];
      pc += 2;
      case (b1[7:6])
        OP_SET_LED: begin
          if (n < LEDS && n < LED_BITS_W) led_word[n] = b2[7];
        end
        OP_REWIND: begin
          pc   = 0;
          pend = wait_from_operand(b2, n);
          why  = (pend == 0) ? CAUSE_ZERO_WAIT : CAUSE_NONE;
          done = 1'b1;
        end
        OP_WAIT: begin
          pend = wait_from_operand(b2, n);
          why  = (pend == 0) ? CAUSE_ZERO_WAIT : CAUSE_NONE;
          done = 1'b1;
        end
        default: begin
          pc   = 0;
          pend = '0;
          why  = CAUSE_RESERVED;
          done = 1'b1;
        end
      endcase
      if (pc >= PROG_BYTES) begin
        pc   = 0;
        pend = '0;
        why  = CAUSE_PAST_END;
        done = 1'b1;
      end
    end
    wait_left  = pend;
    seq_active = (pend != 0);
    return why;
  endfunction

  function automatic led_result_t predict_step(kind_t k, logic [ADDR_W-1:0] a,
                                               logic [BYTE_W-1:0] v);
    led_result_t r;
    cause_t      why;
    why = CAUSE_NONE;
    case (k)
      KIND_WRITE: begin
        if (a < PROG_BYTES) prog_mem[a] = v;
      end
      KIND_START: begin
        pc         = 0;
        wait_left  = 1;
        seq_active = 1'b1;
      end
      KIND_HALT: begin
        seq_active = 1'b0;
        wait_left  = '0;
      end
      default: begin
        if (seq_active) begin
          if (wait_left > 1) begin
            wait_left--;
          end else begin
            wait_left = '0;
            why       = run_program();
          end
        end
      end
    endcase
    r.leds    = led_word;
    r.running = seq_active;
    r.cause   = why;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_item(kind_t k, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] v);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.kind         = k;
    in_chan.byte_address = a;
    in_chan.byte_value   = v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(predict_step(k, a, v));
    items_sent++;
  endtask

  task automatic send_cmd(kind_t k);
    send_item(k, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic write_instr(int unsigned addr, opcode_t op, int unsigned n,
                             logic [BYTE_W-1:0] arg);
    send_item(KIND_WRITE, ADDR_W'(addr), {op, OPERAND_W'(n)});
    send_item(KIND_WRITE, ADDR_W'(addr + 1), arg);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The result side stalls at random, with the same gap profile as the sender.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready = 1'b0;
      stall_left--;
    end else begin
      out_chan.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", results_seen));
      end else begin
        due = expected_results.pop_front();
        if (out_chan.led_bits !== due.leds)
          report_mismatch($sformatf("result %0d led_bits %h, want %h",
                                    results_seen, out_chan.led_bits, due.leds));
        if (out_chan.running !== due.running)
          report_mismatch($sformatf("result %0d running %b, want %b",
                                    results_seen, out_chan.running, due.running));
        if (out_chan.stop_cause !== due.cause)
          report_mismatch($sformatf("result %0d stop_cause %0d, want %0d",
                                    results_seen, out_chan.stop_cause, due.cause));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_halted_commands();
    send_cmd(KIND_TICK);
    send_cmd(KIND_HALT);
    send_item(KIND_WRITE, 12'hFFF, 8'h00);
    send_item(KIND_WRITE, 12'h000, 8'hFF);
  endtask

  task automatic test_led_set_and_wait();
    write_instr(0, OP_SET_LED, 0, 8'h80);
    write_instr(2, OP_SET_LED, 31, 8'hFF);
    write_instr(4, OP_SET_LED, 40, 8'h80);
    write_instr(6, OP_WAIT, 0, 8'h02);
    send_cmd(KIND_START);
    repeat (3) send_cmd(KIND_TICK);
  endtask

  task automatic test_zero_wait();
    write_instr(8, OP_REWIND, 0, 8'h00);
    send_cmd(KIND_START);
    repeat (3) send_cmd(KIND_TICK);
  endtask

  task automatic test_saturated_wait();
    write_instr(6, OP_WAIT, 63, 8'hFF);
    send_cmd(KIND_START);
    repeat (2) send_cmd(KIND_TICK);
    send_cmd(KIND_START);
    send_cmd(KIND_HALT);
  endtask

  task automatic test_random_programs();
    int unsigned round_no;
    int unsigned ins_count;
    int unsigned i;
    int unsigned roll;
    int unsigned steps;
    round_no = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (round_no % 6 == 3) wait_for_results();
      if ($urandom_range(0, 4) == 0) begin
        steps = $urandom_range(3, 8);
        repeat (steps) send_cmd(kind_t'($urandom_range(0, 3)));
      end else begin
        ins_count = $urandom_range(1, 5);
        for (i = 0; i + 1 < ins_count; i++) begin
          roll = $urandom_range(0, 9);
          if (roll < 6)
            write_instr(2 * i, OP_SET_LED,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(32, 63)
                                                     : $urandom_range(0, 31),
                        BYTE_W'($urandom_range(0, 255)));
          else if (roll < 8)
            write_instr(2 * i, OP_WAIT, $urandom_range(0, 1),
                        BYTE_W'($urandom_range(0, 3)));
          else if (roll < 9)
            write_instr(2 * i, OP_WAIT, $urandom_range(56, 63),
                        BYTE_W'($urandom_range(1, 255)));
          else
            write_instr(2 * i, OP_REWIND, $urandom_range(0, 1),
                        BYTE_W'($urandom_range(1, 3)));
        end
        roll = $urandom_range(0, 9);
        if (roll < 5)
          write_instr(2 * i, OP_REWIND, $urandom_range(0, 1),
                      BYTE_W'($urandom_range(0, 3)));
        else if (roll < 8)
          write_instr(2 * i, OP_RESERVED, $urandom_range(0, 63),
                      BYTE_W'($urandom_range(0, 255)));
        else
          write_instr(2 * i, OP_WAIT, $urandom_range(0, 1),
                      BYTE_W'($urandom_range(1, 3)));
        send_cmd(KIND_START);
        steps = $urandom_range(2, 10);
        repeat (steps) begin
          if ($urandom_range(0, 9) == 0) send_cmd(kind_t'($urandom_range(0, 3)));
          else send_cmd(KIND_TICK);
        end
      end
      round_no++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.kind         = KIND_WRITE;
    in_chan.byte_address = '0;
    in_chan.byte_value   = '0;
    out_chan.ready       = 1'b0;
    stall_left           = 0;
    idle_on              = 1'b1;
    items_sent           = 0;
    results_seen         = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    clear_model();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_halted_commands();
    test_led_set_and_wait();
    test_zero_wait();
    test_saturated_wait();
    test_random_programs();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/led_ps_pkg.sv
hw/rtl/led_ps_if.sv
hw/rtl/led_ps_ram.sv
hw/rtl/led_ps_shift.sv
hw/rtl/led_pattern_sequencer_unit.sv
dv/tb_led_pattern_sequencer_unit.sv
